>>> rtl/core/multi_tone_sine_synthesizer_assert.svh
// Assertion macros for the multi-tone sine synthesiser checkers.
// Stand-alone header; no dependencies.
`ifndef MULTI_TONE_SINE_SYNTHESIZER_ASSERT_SVH
`define MULTI_TONE_SINE_SYNTHESIZER_ASSERT_SVH

// Concurrent assertion, disabled while rst is high.
`define MTSS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("mtss assertion failed");

// Concurrent assertion that also holds across reset.
`define MTSS_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("mtss assertion failed");

`endif

>>> rtl/core/mtss_pkg.sv
// Shared constants and types for the multi-tone sine synthesiser.
// No dependencies.
package mtss_pkg;

   localparam int TONES        = 6;
   localparam int SAMPLE_RATE  = 44100;
   localparam int SINE_ENTRIES = 1024;
   localparam int FREQ_REGS    = 6;

   localparam int PHASE_W    = 16;
   localparam int FREQ_W     = 16;
   localparam int SAMPLE_W   = 16;
   localparam int COUNT_W    = 3;
   localparam int CSR_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int TONE_IDX_W = (TONES > 1) ? $clog2(TONES) : 1;

   localparam int SINE_BITS  = $clog2(SINE_ENTRIES);
   localparam int POS_W      = SINE_BITS + 2;
   localparam int ROM_ADDR_W = SINE_BITS + 1;
   localparam int MAG_W      = SAMPLE_W - 1;

   // phase -> table position: floor(p * 4N / rate) as (p * M) >> POS_SHIFT
   localparam int RECIP_SHIFT = 2 * PHASE_W + POS_W;
   localparam int RECIP_W     = 32;
   localparam int PROD_W      = PHASE_W + RECIP_W;
   localparam int POS_SHIFT   = RECIP_SHIFT - POS_W;
   localparam logic [RECIP_W-1:0] PHASE_RECIP =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(SAMPLE_RATE) - 64'd1) / 64'(SAMPLE_RATE));

   // term / tone_count as (term * R) >> DIV_SHIFT
   localparam int DIV_SHIFT   = MAG_W + COUNT_W;
   localparam int DIV_RECIP_W = DIV_SHIFT + 1;
   localparam int SCALED_W    = MAG_W + DIV_RECIP_W;
   localparam logic [DIV_RECIP_W-1:0] COUNT_RECIP [2**COUNT_W] = '{
      DIV_RECIP_W'(1 << DIV_SHIFT),           // zero counts as one
      DIV_RECIP_W'(1 << DIV_SHIFT),
      DIV_RECIP_W'(((1 << DIV_SHIFT) + 1) / 2),
      DIV_RECIP_W'(((1 << DIV_SHIFT) + 2) / 3),
      DIV_RECIP_W'(((1 << DIV_SHIFT) + 3) / 4),
      DIV_RECIP_W'(((1 << DIV_SHIFT) + 4) / 5),
      DIV_RECIP_W'(((1 << DIV_SHIFT) + 5) / 6),
      DIV_RECIP_W'(((1 << DIV_SHIFT) + 6) / 7)
   };

   localparam int SUM_W = SAMPLE_W + $clog2(TONES);

   localparam logic [CSR_IDX_W-1:0] CSR_TONE_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FREQ_0     = 3'd1;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [FREQ_W-1:0]  freq;
   } tone_type;

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
      logic live;
   } token_type;

endpackage

>>> rtl/core/mtss_req_if.sv
// Request channel: valid/ready handshake carrying the restart flag.
// No dependencies.
interface mtss_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

>>> rtl/core/mtss_rsp_if.sv
// Response channel: valid/ready handshake carrying one PCM sample.
// No dependencies.
interface mtss_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

>>> rtl/core/mtss_cell.sv
// One tone cell of the rotating ring: holds a phase and a frequency.
// Depends on mtss_pkg.
module mtss_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wrap,
   input  logic                       shift,
   input  logic                       clear,
   input  logic                       wr_en,
   input  logic [mtss_pkg::FREQ_W-1:0] wr_freq,
   input  mtss_pkg::tone_type         nbr,
   output mtss_pkg::tone_type         tone
);
   import mtss_pkg::*;

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [FREQ_W-1:0]  freq_ff, freq_in;
   logic [FREQ_W-1:0]  step;
   logic [PHASE_W:0]   raw;
   logic [PHASE_W-1:0] adv;

   // phase + freq mod rate, phase already below rate
   always_comb begin
      step = (nbr.freq >= FREQ_W'(SAMPLE_RATE)) ? nbr.freq - FREQ_W'(SAMPLE_RATE) : nbr.freq;
      raw  = {1'b0, nbr.phase} + {1'b0, step};
      adv  = (raw >= (PHASE_W + 1)'(SAMPLE_RATE)) ?
             PHASE_W'(raw - (PHASE_W + 1)'(SAMPLE_RATE)) : PHASE_W'(raw);
   end

   always_comb begin
      phase_in = phase_ff;
      freq_in  = freq_ff;
      if (clear) begin
         phase_in = '0;
      end else if (shift) begin
         phase_in = wrap ? adv : nbr.phase;
         freq_in  = nbr.freq;
      end
      if (wr_en) begin
         freq_in = wr_freq;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         freq_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         freq_ff  <= freq_in;
      end
   end

   assign tone.phase = phase_ff;
   assign tone.freq  = freq_ff;

endmodule

>>> rtl/core/mtss_sine.sv
// Shared sine unit: phase to table position, quarter-wave ROM lookup.
// Two register stages. Depends on mtss_pkg.
module mtss_sine (
   input  logic                        clock,
   input  logic                        reset,
   input  mtss_pkg::token_type         head_tok,
   input  logic [mtss_pkg::PHASE_W-1:0] head_phase,
   output mtss_pkg::token_type         sine_tok,
   output logic [mtss_pkg::MAG_W-1:0]  sine_mag,
   output logic                        sine_neg
);
   import mtss_pkg::*;

   typedef logic [MAG_W-1:0] sine_rom_type [SINE_ENTRIES + 1];

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // sin(pi/2 * k/N) by a 9-term Taylor series in Q2.30, rounded to a Q0.15 magnitude
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      logic [63:0]  x;
      logic [63:0]  t;
      logic [63:0]  v;
      longint       s;
      for (int k = 0; k <= SINE_ENTRIES; k++) begin
         x = (HALF_PI_Q30 * 64'(k)) / 64'(SINE_ENTRIES);
         t = x;
         s = longint'(x);
         for (int n = 1; n <= 8; n++) begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            t = t / 64'((2 * n) * (2 * n + 1));
            if ((n & 1) == 1) begin
               s = s - longint'(t);
            end else begin
               s = s + longint'(t);
            end
         end
         if (s < 0) begin
            s = 0;
         end
         v = ((unsigned'(s) * 64'd32768) + (64'd1 << 29)) >> 30;
         if (v > 64'd32767) begin
            v = 64'd32767;
         end
         rom[k] = MAG_W'(v);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   token_type            s1_tok_ff;
   logic [PROD_W-1:0]    s1_prod_ff;
   token_type            s2_tok_ff;
   logic [MAG_W-1:0]     s2_mag_ff;
   logic                 s2_neg_ff;
   logic [POS_W-1:0]     pos;
   logic [SINE_BITS-1:0] rem;
   logic [ROM_ADDR_W-1:0] addr;

   always_comb begin
      pos  = s1_prod_ff[POS_SHIFT +: POS_W];
      rem  = pos[SINE_BITS-1:0];
      addr = pos[SINE_BITS] ? ROM_ADDR_W'(SINE_ENTRIES) - {1'b0, rem} : {1'b0, rem};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tok_ff <= '0;
         s2_tok_ff <= '0;
      end else begin
         s1_tok_ff <= head_tok;
         s2_tok_ff <= s1_tok_ff;
      end
      s1_prod_ff <= PROD_W'(head_phase) * PROD_W'(PHASE_RECIP);
      s2_mag_ff  <= SINE_ROM[addr];
      s2_neg_ff  <= pos[POS_W-1];
   end

   assign sine_tok = s2_tok_ff;
   assign sine_mag = s2_mag_ff;
   assign sine_neg = s2_neg_ff;

endmodule

>>> rtl/core/mtss_accum.sv
// Scales each sine term by the tone count, sums terms and saturates.
// Two register stages. Depends on mtss_pkg.
module mtss_accum (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [mtss_pkg::COUNT_W-1:0]      tone_count,
   input  mtss_pkg::token_type               sine_tok,
   input  logic [mtss_pkg::MAG_W-1:0]        sine_mag,
   input  logic                              sine_neg,
   output logic                              done,
   output logic signed [mtss_pkg::SAMPLE_W-1:0] sum
);
   import mtss_pkg::*;

   localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'((1 << (SAMPLE_W - 1)) - 1);
   localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(-(1 << (SAMPLE_W - 1)));

   token_type               s3_tok_ff;
   logic [SCALED_W-1:0]     s3_scaled_ff;
   logic                    s3_neg_ff;
   logic signed [SUM_W-1:0] acc_ff, acc_in;
   logic                    done_ff, done_in;
   logic [MAG_W-1:0]        quot;
   logic signed [SUM_W-1:0] mag_term;
   logic signed [SUM_W-1:0] term;

   always_comb begin
      quot     = s3_scaled_ff[DIV_SHIFT +: MAG_W];
      mag_term = $signed(SUM_W'(quot));
      if (!s3_tok_ff.live) begin
         term = '0;
      end else if (s3_neg_ff) begin
         term = -mag_term;
      end else begin
         term = mag_term;
      end
      acc_in  = acc_ff;
      done_in = done_ff;
      if (start) begin
         done_in = 1'b0;
      end
      if (s3_tok_ff.valid) begin
         acc_in = s3_tok_ff.first ? term : acc_ff + term;
         if (s3_tok_ff.last) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_tok_ff <= '0;
         done_ff   <= 1'b0;
      end else begin
         s3_tok_ff <= sine_tok;
         done_ff   <= done_in;
      end
      s3_scaled_ff <= SCALED_W'(sine_mag) * SCALED_W'(COUNT_RECIP[tone_count]);
      s3_neg_ff    <= sine_neg;
      acc_ff       <= acc_in;
   end

   always_comb begin
      if (acc_ff > SAT_MAX) begin
         sum = SAMPLE_W'(SAT_MAX);
      end else if (acc_ff < SAT_MIN) begin
         sum = SAMPLE_W'(SAT_MIN);
      end else begin
         sum = SAMPLE_W'(acc_ff);
      end
   end

   assign done = done_ff;

endmodule

>>> rtl/core/multi_tone_sine_synthesizer.sv
// Multi-tone sine synthesiser: one saturated PCM sample per request.
// An accepted request spins the tone ring, rotating one tone a cycle through the
// shared sine unit and its 4-stage drain; the result is registered once the response
// slot is free, and only then is a new request accepted.
// Reset: phases and frequencies zero, tone count one, no result held.
module multi_tone_sine_synthesizer (
   input  logic                          clock,
   input  logic                          reset,
   mtss_req_if.sink                      req_ch,
   mtss_rsp_if.source                    rsp_ch,
   input  logic                          csr_wr_en,
   input  logic [mtss_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mtss_pkg::CSR_W-1:0]    csr_wdata
);
   import mtss_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SPIN,
      ST_WAIT
   } state_type;

   state_type              state_ff, state_in;
   logic [TONE_IDX_W-1:0]  spin_ff, spin_in;
   logic                   live_ff, live_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic [COUNT_W-1:0]     count_ff;

   tone_type               tone [TONES];
   token_type              head_tok;
   token_type              sine_tok;
   logic [MAG_W-1:0]       sine_mag;
   logic                   sine_neg;
   logic                   acc_done;
   logic signed [SAMPLE_W-1:0] acc_sum;
   logic                   req_acc;
   logic                   rsp_free;
   logic                   shift;

   assign req_ch.ready  = (state_ff == ST_IDLE);
   assign req_acc       = req_ch.valid && req_ch.ready;
   assign rsp_free      = !rsp_valid_ff || rsp_ch.ready;
   assign shift         = (state_ff == ST_SPIN);
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.sample = rsp_sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_W'(1);
      end else if (csr_wr_en && csr_index == CSR_TONE_COUNT) begin
         count_ff <= csr_wdata[COUNT_W-1:0];
      end
   end

   for (genvar i = 0; i < TONES; i++) begin : g_cell
      tone_type nbr;
      logic     wr;
      if (i == TONES - 1) begin : g_tail
         assign nbr = tone[0];
      end else begin : g_body
         assign nbr = tone[i + 1];
      end
      if (i < FREQ_REGS) begin : g_reg
         assign wr = csr_wr_en && (csr_index == CSR_IDX_W'(CSR_FREQ_0 + i));
      end else begin : g_noreg
         assign wr = 1'b0;
      end
      mtss_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .wrap    (i == TONES - 1),
         .shift   (shift),
         .clear   (req_acc && req_ch.restart),
         .wr_en   (wr),
         .wr_freq (csr_wdata[FREQ_W-1:0]),
         .nbr     (nbr),
         .tone    (tone[i])
      );
   end

   // tones after the first silent one stay silent
   always_comb begin
      head_tok.valid = shift;
      head_tok.first = (spin_ff == '0);
      head_tok.last  = (spin_ff == TONE_IDX_W'(TONES - 1));
      head_tok.live  = live_ff && (tone[0].freq != '0);
   end

   mtss_sine u_sine (
      .clock      (clock),
      .reset      (reset),
      .head_tok   (head_tok),
      .head_phase (tone[0].phase),
      .sine_tok   (sine_tok),
      .sine_mag   (sine_mag),
      .sine_neg   (sine_neg)
   );

   mtss_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .start      (req_acc),
      .tone_count (count_ff),
      .sine_tok   (sine_tok),
      .sine_mag   (sine_mag),
      .sine_neg   (sine_neg),
      .done       (acc_done),
      .sum        (acc_sum)
   );

   always_comb begin
      state_in      = state_ff;
      spin_in       = spin_ff;
      live_in       = live_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_sample_in = rsp_sample_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = ST_SPIN;
               spin_in  = '0;
               live_in  = 1'b1;
            end
         end
         ST_SPIN: begin
            live_in = head_tok.live;
            if (head_tok.last) begin
               state_in = ST_WAIT;
            end else begin
               spin_in = spin_ff + TONE_IDX_W'(1);
            end
         end
         ST_WAIT: begin
            if (acc_done && rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = acc_sum;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         spin_ff      <= '0;
         live_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         spin_ff      <= spin_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_sample_ff <= rsp_sample_in;
   end

endmodule

>>> rtl/core/mtss_checker.sv
// Port-level checks for the multi-tone sine synthesiser, bound to the top level.
// Depends on multi_tone_sine_synthesizer_assert.svh.
`include "multi_tone_sine_synthesizer_assert.svh"

module mtss_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_sample
);

   `MTSS_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)
   `MTSS_ASSERT(a_one_request, clock, reset, req_valid && req_ready |=> !req_ready)
   `MTSS_ASSERT(a_result_from_work, clock, reset, $rose(rsp_valid) |-> $past(!req_ready))
   `MTSS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample))

endmodule

bind multi_tone_sine_synthesizer mtss_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_sample (rsp_ch.sample)
);
